[src/bss_pkg.sv]
// Package for the SAH split selector: payload structs, box types and the box union.
// No dependencies; every other file of the block imports it.
package bss_pkg;

  localparam int COORD_W = 16;
  localparam int ID_W    = 24;
  localparam int SPLIT_W = 7;
  localparam int AXIS_W  = 2;
  localparam int CNT_W   = 7;   // holds a primitive count of up to 127
  localparam int EXT_W   = 17;  // exact extent max - min
  localparam int PROD_W  = 34;
  localparam int AREA_W  = 36;
  localparam int COST_W  = 46;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cent_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic signed [COORD_W-1:0] centroid_z;
    logic [ID_W-1:0]           prim_id;
    logic                      last_prim;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]    sorted_id;
    logic [SPLIT_W-1:0] split_pos;
    logic [AXIS_W-1:0]  chosen_axis;
    logic               last_out;
  } res_t;

  // one stored primitive
  typedef struct packed {
    box_t            box;
    cent_t           cent;
    logic [ID_W-1:0] id;
  } prim_t;

  // one closed run, handed from loader to engine
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    box_t             parent;
  } job_t;

  function automatic box_t box_merge(box_t a, box_t b);
    box_t r;
    r.min_x = (b.min_x < a.min_x) ? b.min_x : a.min_x;
    r.min_y = (b.min_y < a.min_y) ? b.min_y : a.min_y;
    r.min_z = (b.min_z < a.min_z) ? b.min_z : a.min_z;
    r.max_x = (b.max_x > a.max_x) ? b.max_x : a.max_x;
    r.max_y = (b.max_y > a.max_y) ? b.max_y : a.max_y;
    r.max_z = (b.max_z > a.max_z) ? b.max_z : a.max_z;
    return r;
  endfunction

endpackage

[src/bss_front.sv]
// Loader: stores each accepted primitive while the store has room, keeps the parent union and closes runs.
// Depends on bss_pkg.
module bss_front #(
  parameter int MAX_PRIMS = 32,
  parameter int IW = 5,
  parameter int CW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  bss_pkg::in_t    item_i,
  output logic            wr_en_o,
  output logic [IW-1:0]   wr_addr_o,
  output bss_pkg::prim_t  wr_prim_o,
  output logic            push_o,
  output bss_pkg::job_t   job_o
);
  import bss_pkg::*;

  logic [CW-1:0] count_q, count_d;
  box_t          parent_q, parent_d;
  box_t          in_box, merged;
  logic          has_room;

  // unpack the request into store format
  always_comb begin
    in_box.min_x = item_i.box_min_x;
    in_box.min_y = item_i.box_min_y;
    in_box.min_z = item_i.box_min_z;
    in_box.max_x = item_i.box_max_x;
    in_box.max_y = item_i.box_max_y;
    in_box.max_z = item_i.box_max_z;
    wr_prim_o.box    = in_box;
    wr_prim_o.cent.x = item_i.centroid_x;
    wr_prim_o.cent.y = item_i.centroid_y;
    wr_prim_o.cent.z = item_i.centroid_z;
    wr_prim_o.id     = item_i.prim_id;
  end

  assign has_room  = count_q < CW'(MAX_PRIMS);
  assign merged    = (count_q == '0) ? in_box : box_merge(parent_q, in_box);
  assign wr_en_o   = accept_i && has_room;
  assign wr_addr_o = count_q[IW-1:0];

  // close the run on the last request; a full store drops the item but keeps the run
  always_comb begin
    count_d    = count_q;
    parent_d   = parent_q;
    push_o     = 1'b0;
    job_o.cnt  = CNT_W'(count_q);
    job_o.parent = parent_q;
    if (accept_i) begin
      if (has_room) begin
        count_d      = count_q + 1'b1;
        parent_d     = merged;
        job_o.cnt    = CNT_W'(count_d);
        job_o.parent = merged;
      end
      if (item_i.last_prim) begin
        push_o   = 1'b1;
        count_d  = '0;
        parent_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      parent_q <= '0;
    end else begin
      count_q  <= count_d;
      parent_q <= parent_d;
    end
  end

endmodule

[src/bss_job_queue.sv]
// Two-entry queue of closed runs between loader and engine.
// Depends on bss_pkg.
module bss_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bss_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          empty_o,
  output bss_pkg::job_t head_o
);
  import bss_pkg::*;

  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;

  assign empty_o = (fill_q == 2'd0);
  assign head_o  = slot_q[rp_q];

  // store payload
  always_ff @(posedge clk_i) begin
    if (push_i && fill_q != 2'd2) slot_q[wp_q] <= job_i;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i && fill_q != 2'd2) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, push_i && fill_q != 2'd2} - {1'b0, pop_i && !empty_o};
    end
  end

endmodule

[src/bss_area.sv]
// Sequential area-times-count unit: (ex*ey + ey*ez + ez*ex) * cnt, one multiply a cycle.
// Depends on bss_pkg.
module bss_area #(
  parameter int CW = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  bss_pkg::box_t                        box_i,
  input  logic [CW-1:0]                        cnt_i,
  output logic                                 done_o,
  output logic signed [bss_pkg::COST_W-1:0]    cost_o
);
  import bss_pkg::*;

  logic signed [EXT_W-1:0]      ex_q, ey_q, ez_q, mul_a, mul_b;
  logic [CW-1:0]                cnt_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [AREA_W-1:0]     acc_q;
  logic signed [AREA_W+CW:0]    scaled;
  logic [2:0]                   ph_q;
  logic                         run_q;

  // pick the extent pair of this phase
  always_comb begin
    case (ph_q)
      3'd0:    begin mul_a = ex_q; mul_b = ey_q; end
      3'd1:    begin mul_a = ey_q; mul_b = ez_q; end
      default: begin mul_a = ez_q; mul_b = ex_q; end
    endcase
  end

  assign scaled = acc_q * $signed({1'b0, cnt_q});

  // latch extents, then multiply and accumulate
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      ex_q  <= EXT_W'(box_i.max_x) - EXT_W'(box_i.min_x);
      ey_q  <= EXT_W'(box_i.max_y) - EXT_W'(box_i.min_y);
      ez_q  <= EXT_W'(box_i.max_z) - EXT_W'(box_i.min_z);
      cnt_q <= cnt_i;
    end else if (run_q) begin
      if (ph_q < 3'd3) prod_q <= mul_a * mul_b;
      if (ph_q == 3'd1) acc_q <= AREA_W'(prod_q);
      else if (ph_q == 3'd2 || ph_q == 3'd3) acc_q <= acc_q + AREA_W'(prod_q);
      if (ph_q == 3'd4) cost_o <= COST_W'(scaled);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ph_q   <= 3'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        ph_q  <= 3'd0;
      end else if (run_q) begin
        ph_q <= ph_q + 3'd1;
        if (ph_q == 3'd4) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

[src/bss_back.sv]
// Engine: primitive stores, rank sort, suffix unions, SAH sweep and result emission.
// Depends on bss_pkg and bss_area.
module bss_back #(
  parameter int MAX_PRIMS = 32,
  parameter int IW = 5,
  parameter int CW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IW-1:0]   wr_addr_i,
  input  bss_pkg::prim_t  wr_prim_i,
  input  logic            q_empty_i,
  input  bss_pkg::job_t   q_head_i,
  output logic            pop_o,
  output logic            busy_o,
  output logic            res_valid_o,
  output bss_pkg::res_t   res_o
);
  import bss_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE, B_PARW, B_RK_I, B_RK_K, B_RK_J, B_RK_W,
    B_SF_O, B_SF_B, B_SF_M, B_SW_O, B_SW_B, B_SW_M, B_SW_L, B_SW_R,
    B_EM_O, B_EM_I, B_EM_E
  } state_e;

  // stores
  box_t            box_mem  [MAX_PRIMS];
  cent_t           cent_mem [MAX_PRIMS];
  logic [ID_W-1:0] id_mem   [MAX_PRIMS];
  box_t            suf_mem  [MAX_PRIMS];
  logic [IW-1:0]   ord_mem  [MAX_PRIMS];

  box_t            box_rd_q, suf_rd_q;
  cent_t           cent_rd_q;
  logic [ID_W-1:0] id_rd_q;
  logic [IW-1:0]   ord_rd_q;

  state_e                     state_q;
  logic [CW-1:0]              n_q, split_q;
  logic [AXIS_W-1:0]          axis_q, axis_c;
  logic [IW-1:0]              i_q, j_q, rank_q, nm1, ord_addr, cent_addr;
  logic signed [COORD_W-1:0]  key_i_q, key_j;
  box_t                       left_q, left_c, sacc_q, sacc_c, area_box_q;
  logic [CW-1:0]              area_cnt_q;
  logic                       area_go_q, area_done;
  logic signed [COST_W-1:0]   area_cost, best_q, costl_q, cost_c;
  logic [EXT_W-1:0]           abs_x, abs_y, abs_z;
  logic signed [EXT_W-1:0]    dx, dy, dz;

  function automatic logic signed [COORD_W-1:0] key_sel(cent_t c, logic [AXIS_W-1:0] a);
    case (a)
      AXIS_Y:  return c.y;
      AXIS_Z:  return c.z;
      default: return c.x;
    endcase
  endfunction

  assign nm1    = IW'(n_q - 1'b1);
  assign key_j  = key_sel(cent_rd_q, axis_q);
  assign busy_o = (state_q != B_IDLE);
  assign pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign left_c = (i_q == IW'(1)) ? box_rd_q : box_merge(left_q, box_rd_q);
  assign sacc_c = (i_q == nm1) ? box_rd_q : box_merge(sacc_q, box_rd_q);
  assign cost_c = costl_q + area_cost;

  // longest axis of the parent box, axis 0 without a strict maximum
  always_comb begin
    dx = EXT_W'(q_head_i.parent.max_x) - EXT_W'(q_head_i.parent.min_x);
    dy = EXT_W'(q_head_i.parent.max_y) - EXT_W'(q_head_i.parent.min_y);
    dz = EXT_W'(q_head_i.parent.max_z) - EXT_W'(q_head_i.parent.min_z);
    abs_x = dx[EXT_W-1] ? EXT_W'(-dx) : EXT_W'(dx);
    abs_y = dy[EXT_W-1] ? EXT_W'(-dy) : EXT_W'(dy);
    abs_z = dz[EXT_W-1] ? EXT_W'(-dz) : EXT_W'(dz);
    if (abs_y > abs_x && abs_y > abs_z) axis_c = AXIS_Y;
    else if (abs_z > abs_x && abs_z > abs_y) axis_c = AXIS_Z;
    else axis_c = AXIS_X;
  end

  // read addresses
  always_comb begin
    case (state_q)
      B_SW_O, B_SW_B, B_SW_M, B_SW_L, B_SW_R: ord_addr = i_q - 1'b1;
      default:                                ord_addr = i_q;
    endcase
    case (state_q)
      B_RK_K:  cent_addr = '0;
      B_RK_J:  cent_addr = j_q + 1'b1;
      default: cent_addr = i_q;
    endcase
  end

  // memories: one write, registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      box_mem[wr_addr_i]  <= wr_prim_i.box;
      cent_mem[wr_addr_i] <= wr_prim_i.cent;
      id_mem[wr_addr_i]   <= wr_prim_i.id;
    end
    if (state_q == B_RK_W) ord_mem[rank_q] <= i_q;
    if (state_q == B_SF_M) suf_mem[i_q] <= sacc_c;
    ord_rd_q  <= ord_mem[ord_addr];
    box_rd_q  <= box_mem[ord_rd_q];
    id_rd_q   <= id_mem[ord_rd_q];
    cent_rd_q <= cent_mem[cent_addr];
    suf_rd_q  <= suf_mem[i_q];
  end

  bss_area #(.CW(CW)) u_area (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (area_go_q),
    .box_i  (area_box_q),
    .cnt_i  (area_cnt_q),
    .done_o (area_done),
    .cost_o (area_cost)
  );

  // sequencer: parent cost, rank sort, suffix pass, sweep, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      area_go_q   <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      area_go_q   <= 1'b0;
      res_valid_o <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            n_q        <= CW'(q_head_i.cnt);
            axis_q     <= axis_c;
            split_q    <= CW'(1);
            area_box_q <= q_head_i.parent;
            area_cnt_q <= CW'(q_head_i.cnt);
            area_go_q  <= 1'b1;
            state_q    <= B_PARW;
          end
        end
        B_PARW: begin
          if (area_done) begin
            best_q  <= area_cost;
            i_q     <= '0;
            state_q <= B_RK_I;
          end
        end
        B_RK_I: state_q <= B_RK_K;
        B_RK_K: begin
          key_i_q <= key_j;
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= B_RK_J;
        end
        B_RK_J: begin
          if (key_j < key_i_q || (key_j == key_i_q && j_q < i_q)) rank_q <= rank_q + 1'b1;
          if (j_q == nm1) state_q <= B_RK_W;
          else j_q <= j_q + 1'b1;
        end
        B_RK_W: begin
          if (i_q == nm1) begin
            state_q <= B_SF_O;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= B_RK_I;
          end
        end
        B_SF_O: state_q <= B_SF_B;
        B_SF_B: state_q <= B_SF_M;
        B_SF_M: begin
          sacc_q <= sacc_c;
          if (i_q == '0) begin
            if (n_q == CW'(1)) begin
              state_q <= B_EM_O;
            end else begin
              i_q     <= IW'(1);
              state_q <= B_SW_O;
            end
          end else begin
            i_q     <= i_q - 1'b1;
            state_q <= B_SF_O;
          end
        end
        B_SW_O: state_q <= B_SW_B;
        B_SW_B: state_q <= B_SW_M;
        B_SW_M: begin
          left_q     <= left_c;
          area_box_q <= left_c;
          area_cnt_q <= CW'(i_q);
          area_go_q  <= 1'b1;
          state_q    <= B_SW_L;
        end
        B_SW_L: begin
          if (area_done) begin
            costl_q    <= area_cost;
            area_box_q <= suf_rd_q;
            area_cnt_q <= n_q - CW'(i_q);
            area_go_q  <= 1'b1;
            state_q    <= B_SW_R;
          end
        end
        B_SW_R: begin
          if (area_done) begin
            if (cost_c < best_q) begin
              best_q  <= cost_c;
              split_q <= CW'(i_q);
            end
            if (i_q == nm1) begin
              i_q     <= '0;
              state_q <= B_EM_O;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= B_SW_O;
            end
          end
        end
        B_EM_O: state_q <= B_EM_I;
        B_EM_I: state_q <= B_EM_E;
        B_EM_E: begin
          res_valid_o       <= 1'b1;
          res_o.sorted_id   <= id_rd_q;
          res_o.split_pos   <= SPLIT_W'(split_q);
          res_o.chosen_axis <= axis_q;
          res_o.last_out    <= (i_q == nm1);
          if (i_q == nm1) begin
            state_q <= B_IDLE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= B_EM_O;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[src/bvh_sah_split_select.sv]
// Top level of the SAH split selector: loader, run queue and engine.
// Depends on bss_pkg, bss_front, bss_job_queue, bss_back.
//
//   channel   signals                          direction  handshake
//   request   start, busy, item_i              in         start && !busy
//   result    result_valid_o, result_o         out        strobe, one cycle each
//
// The loader takes one primitive per cycle while busy is low. After the last one
// the engine computes the parent cost, then runs the rank sort (one centroid
// read a cycle), the suffix unions, the sweep of each split through the shared
// area multiplier, and the emission of the results; busy is high meanwhile.
// Reset clears counters and control; the stores need no clearing. The receiver
// cannot stall, so results leave at the engine's own pace.
module bvh_sah_split_select #(
  parameter int MAX_PRIMS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bss_pkg::in_t   item_i,
  output logic           result_valid_o,
  output bss_pkg::res_t  result_o
);
  import bss_pkg::*;

  localparam int IW = (MAX_PRIMS > 1) ? $clog2(MAX_PRIMS) : 1;
  localparam int CW = $clog2(MAX_PRIMS + 1);

  logic          accept, wr_en, push, q_empty, pop, back_busy;
  logic [IW-1:0] wr_addr;
  prim_t         wr_prim;
  job_t          job, q_head;

  assign busy   = !q_empty || back_busy;
  assign accept = start && !busy;

  bss_front #(.MAX_PRIMS(MAX_PRIMS), .IW(IW), .CW(CW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_prim_o (wr_prim),
    .push_o    (push),
    .job_o     (job)
  );

  bss_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  bss_back #(.MAX_PRIMS(MAX_PRIMS), .IW(IW), .CW(CW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_prim_i   (wr_prim),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

[src/bss_checker.sv]
// Port-level checks for the SAH split selector, bound to the top level.
// Depends on bss_pkg and bvh_sah_split_select.
module bss_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input bss_pkg::in_t  item_i,
  input logic          result_valid_o,
  input bss_pkg::res_t result_o
);
  import bss_pkg::*;

  // a closing request starts the engine
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.last_prim |=> busy)
    else $error("closing request did not raise busy");

  // results come only from a run in progress
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy || $past(busy))
    else $error("result outside a run");

  // the final result is followed by a gap
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_out |=> !result_valid_o)
    else $error("result right after final result");

  // split and axis stay legal
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.split_pos != '0 && result_o.chosen_axis <= AXIS_Z)
    else $error("illegal split or axis");

endmodule

bind bvh_sah_split_select bss_checker u_bss_checker (.*);

[dv/bvh_sah_split_select_tb.sv]
// Testbench for bvh_sah_split_select: directed table, then random runs of primitives.
// Depends on bss_pkg and the block's RTL; checks sorted ids, split, axis and last flag per result.
`timescale 1ns / 100ps

module bvh_sah_split_select_tb;
  import bss_pkg::*;

  localparam int MAX_PRIMS  = 32;
  localparam int RAND_ITEMS = 156;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  item_i = '0;
  logic result_valid_o;
  res_t result_o;

  bvh_sah_split_select #(.MAX_PRIMS(MAX_PRIMS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the loader: primitives of the open run and their union
  box_t  ld_box[$];
  cent_t ld_cent[$];
  logic [ID_W-1:0] ld_id[$];
  box_t  parent_box;
  res_t  sorted_q[$];
  int    fail_cnt = 0;
  int    runs_done = 0;
  int    results_seen = 0;
  int    items_sent = 0;

  typedef struct {
    in_t  item;
    bit   typed;
    res_t want;
  } row_t;
  row_t rows[$];

  function automatic longint area_of(box_t b);
    longint ex, ey, ez;
    ex = longint'(b.max_x) - longint'(b.min_x);
    ey = longint'(b.max_y) - longint'(b.min_y);
    ez = longint'(b.max_z) - longint'(b.min_z);
    return ex * ey + ey * ez + ez * ex;
  endfunction

  function automatic box_t union_of(box_t a, box_t b);
    box_t r;
    r.min_x = (b.min_x < a.min_x) ? b.min_x : a.min_x;
    r.min_y = (b.min_y < a.min_y) ? b.min_y : a.min_y;
    r.min_z = (b.min_z < a.min_z) ? b.min_z : a.min_z;
    r.max_x = (b.max_x > a.max_x) ? b.max_x : a.max_x;
    r.max_y = (b.max_y > a.max_y) ? b.max_y : a.max_y;
    r.max_z = (b.max_z > a.max_z) ? b.max_z : a.max_z;
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] key_of(cent_t c, logic [AXIS_W-1:0] ax);
    if (ax == AXIS_Y) return c.y;
    if (ax == AXIS_Z) return c.z;
    return c.x;
  endfunction

  // Load one accepted request; on the last one, sort, sweep and queue the results.
  task automatic predict_split(in_t it);
    box_t b, lft;
    box_t suf[MAX_PRIMS];
    cent_t c;
    longint ex, ey, ez, best, cost;
    logic [AXIS_W-1:0] ax;
    int order[$];
    int n, j, split;
    res_t r;
    b = '{it.box_min_x, it.box_min_y, it.box_min_z, it.box_max_x, it.box_max_y, it.box_max_z};
    c = '{it.centroid_x, it.centroid_y, it.centroid_z};
    if (ld_box.size() < MAX_PRIMS) begin
      parent_box = (ld_box.size() == 0) ? b : union_of(parent_box, b);
      ld_box = {ld_box, b};
      ld_cent = {ld_cent, c};
      ld_id = {ld_id, it.prim_id};
    end
    if (!it.last_prim) return;
    n = ld_box.size();
    ex = longint'(parent_box.max_x) - longint'(parent_box.min_x);
    ey = longint'(parent_box.max_y) - longint'(parent_box.min_y);
    ez = longint'(parent_box.max_z) - longint'(parent_box.min_z);
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    if (ez < 0) ez = -ez;
    ax = AXIS_X;
    if (ey > ex && ey > ez) ax = AXIS_Y;
    else if (ez > ex && ez > ey) ax = AXIS_Z;
    // stable insertion by centroid key
    for (int i = 0; i < n; i++) begin
      j = order.size();
      while (j > 0 && key_of(ld_cent[order[j-1]], ax) > key_of(ld_cent[i], ax)) j--;
      order.insert(j, i);
    end
    suf[n-1] = ld_box[order[n-1]];
    for (int i = n - 1; i > 0; i--) suf[i-1] = union_of(suf[i], ld_box[order[i-1]]);
    best = area_of(parent_box) * n;
    split = 1;
    lft = ld_box[order[0]];
    for (int i = 1; i < n; i++) begin
      if (i > 1) lft = union_of(lft, ld_box[order[i-1]]);
      cost = area_of(lft) * i + area_of(suf[i]) * (n - i);
      if (cost < best) begin
        best = cost;
        split = i;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.sorted_id = ld_id[order[i]];
      r.split_pos = split[SPLIT_W-1:0];
      r.chosen_axis = ax;
      r.last_out = (i == n - 1);
      sorted_q = {sorted_q, r};
    end
    ld_box.delete();
    ld_cent.delete();
    ld_id.delete();
    parent_box = '0;
    runs_done++;
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        $error("unexpected result id=%h", result_o.sorted_id);
        fail_cnt++;
      end else begin
        res_t w;
        w = sorted_q.pop_front();
        if (result_o.sorted_id !== w.sorted_id) begin
          $error("sorted_id: expected %h actual %h", w.sorted_id, result_o.sorted_id);
          fail_cnt++;
        end
        if (result_o.split_pos !== w.split_pos) begin
          $error("split_pos: expected %0d actual %0d", w.split_pos, result_o.split_pos);
          fail_cnt++;
        end
        if (result_o.chosen_axis !== w.chosen_axis) begin
          $error("chosen_axis: expected %0d actual %0d", w.chosen_axis, result_o.chosen_axis);
          fail_cnt++;
        end
        if (result_o.last_out !== w.last_out) begin
          $error("last_out: expected %0d actual %0d", w.last_out, result_o.last_out);
          fail_cnt++;
        end
      end
    end
  end

  function automatic in_t mk(int x0, int y0, int z0, int x1, int y1, int z1,
                             int cx, int cy, int cz, int id, bit lst);
    in_t t;
    t.box_min_x = COORD_W'(x0); t.box_min_y = COORD_W'(y0); t.box_min_z = COORD_W'(z0);
    t.box_max_x = COORD_W'(x1); t.box_max_y = COORD_W'(y1); t.box_max_z = COORD_W'(z1);
    t.centroid_x = COORD_W'(cx); t.centroid_y = COORD_W'(cy); t.centroid_z = COORD_W'(cz);
    t.prim_id = ID_W'(id);
    t.last_prim = lst;
    return t;
  endfunction

  function automatic void add_row(in_t it, bit typed, res_t want);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endfunction

  // Random primitive: mostly ordered boxes, some inverted, keys sometimes clustered.
  function automatic in_t rand_prim(bit lst);
    in_t t;
    logic signed [COORD_W-1:0] a, b;
    logic signed [COORD_W-1:0] lo[3], hi[3];
    for (int k = 0; k < 3; k++) begin
      a = COORD_W'($urandom);
      b = COORD_W'($urandom);
      if ($urandom_range(0, 9) != 0 && a > b) begin
        lo[k] = b; hi[k] = a;
      end else begin
        lo[k] = a; hi[k] = b;
      end
    end
    t.box_min_x = lo[0]; t.box_min_y = lo[1]; t.box_min_z = lo[2];
    t.box_max_x = hi[0]; t.box_max_y = hi[1]; t.box_max_z = hi[2];
    if ($urandom_range(0, 3) == 0) begin
      t.centroid_x = COORD_W'($signed($urandom_range(0, 3)) - 2);
      t.centroid_y = COORD_W'($signed($urandom_range(0, 3)) - 2);
      t.centroid_z = COORD_W'($signed($urandom_range(0, 3)) - 2);
    end else begin
      t.centroid_x = COORD_W'($urandom);
      t.centroid_y = COORD_W'($urandom);
      t.centroid_z = COORD_W'($urandom);
    end
    t.prim_id = ID_W'($urandom);
    t.last_prim = lst;
    return t;
  endfunction

  int burst_left = 0;

  // Hold the request until accepted, then record it and maybe open a gap.
  task automatic send_prim(in_t it);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int len;
    int sent;
    res_t none;
    bit over_done;
    bit full_done;
    none = '0;
    over_done = 1'b0;
    full_done = 1'b0;
    // single primitive spanning the full range, ties on every axis
    add_row(mk(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 'hFFFFFF, 1), 1,
            '{24'hFFFFFF, 7'd1, AXIS_X, 1'b1});
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, '{24'h0, 7'd1, AXIS_X, 1'b1});
    // y longest, equal keys keep load order
    add_row(mk(0, -1000, 0, 10, 0, 10, 5, 7, 0, 'h11, 0), 0, none);
    add_row(mk(0, 0, 0, 10, 1000, 10, 5, 7, 0, 'h22, 0), 0, none);
    add_row(mk(0, 100, 0, 10, 200, 10, 5, -3, 0, 'h33, 1), 0, none);
    // z longest through inverted boxes
    add_row(mk(5, 5, 3000, 0, 0, -3000, 0, 0, 9, 'h44, 0), 0, none);
    add_row(mk(0, 0, 100, 4, 4, 50, 0, 0, -9, 'h55, 0), 0, none);
    add_row(mk(1, 1, 0, 2, 2, 1, 0, 0, 0, 'h66, 1), 0, none);
    // key extremes along x, two clusters so the sweep finds a real split
    add_row(mk(-32768, 0, 0, -32000, 10, 10, 32767, 0, 0, 'hABCDEF, 0), 0, none);
    add_row(mk(32000, 0, 0, 32767, 10, 10, -32768, 0, 0, 'h123456, 0), 0, none);
    add_row(mk(-32700, 0, 0, -32100, 10, 10, 32767, 0, 0, 'h000001, 0), 0, none);
    add_row(mk(31000, 0, 0, 32500, 10, 10, -32768, 0, 0, 'h800000, 1), 0, none);
    // identical boxes: no split beats the parent
    add_row(mk(0, 0, 0, 256, 256, 256, 3, 2, 1, 'h7, 0), 0, none);
    add_row(mk(0, 0, 0, 256, 256, 256, 1, 2, 3, 'h8, 1), 0, none);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (rows[i]) begin
      send_prim(rows[i].item);
      predict_split(rows[i].item);
      if (rows[i].typed) begin
        void'(sorted_q.pop_back());
        sorted_q = {sorted_q, rows[i].want};
      end
    end

    // random runs; one overfills the store and one sits at exactly full
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (!over_done && sent >= 40) begin
        len = MAX_PRIMS + 2;
        over_done = 1'b1;
      end else if (!full_done && sent >= 100) begin
        len = MAX_PRIMS;
        full_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 9);
      end
      for (int k = 0; k < len; k++) begin
        in_t it;
        it = rand_prim(k == len - 1);
        send_prim(it);
        predict_split(it);
      end
      sent += len;
      // drain fully once mid-run
      if (sent >= 80 && sent - len < 80) begin
        start <= 1'b0;
        while (sorted_q.size() != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests in %0d runs, %0d sorted results checked.",
             items_sent, runs_done, results_seen);
    if (fail_cnt == 0) begin
      $display("PASS bvh_sah_split_select");
    end else begin
      $display("FAIL bvh_sah_split_select");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL bvh_sah_split_select");
    $finish;
  end

endmodule
